@@ rtl/core/krta_pkg.sv @@
// Package for the keypad range temperature alarm: operation codes, key codes,
// reset values, the result record and the keypad decode function.
// No dependencies.
`timescale 1ns / 1ps

package krta_pkg;

  // Operation codes of an input request
  localparam logic [1:0] OP_KEY  = 2'd0;
  localparam logic [1:0] OP_TEMP = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_BEEP_HALF = 2'd0;
  localparam logic [1:0] CFG_SNOOZE    = 2'd1;
  localparam logic [1:0] CFG_UPPER_LIM = 2'd2;

  // Decoded key values; 0..9 are the digits themselves
  localparam logic [3:0] KEY_DIGIT_MAX = 4'd9;
  localparam logic [3:0] KEY_OTHER     = 4'd10;
  localparam logic [3:0] KEY_C         = 4'd11;
  localparam logic [3:0] KEY_D         = 4'd12;

  // Entry error codes
  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_ORDER  = 2'd1;
  localparam logic [1:0] ERR_LIMITS = 2'd2;

  localparam logic [2:0] ENTRY_DIGITS = 3'd4;

  // Reset values
  localparam logic [15:0] BEEP_HALF_RST = 16'd500;
  localparam logic [17:0] SNOOZE_RST    = 18'd60000;
  localparam logic [6:0]  UPPER_LIM_RST = 7'd50;
  localparam logic [6:0]  LOWER_RST     = 7'd10;
  localparam logic [6:0]  UPPER_RST     = 7'd35;

  typedef struct packed {
    logic       buzzer_on;
    logic       out_of_range;
    logic       entry_mode;
    logic [2:0] digits_taken;
    logic [1:0] entry_error;
    logic       entry_done;
    logic [6:0] low_bound;
    logic [6:0] high_bound;
    logic       snooze_pending;
  } res_t;

  // Keypad rows "123A", "456B", "789C", "*0#D"
  function automatic logic [3:0] key_decode(input logic [3:0] idx);
    logic [3:0] code;
    unique case (idx)
      4'd0:    code = 4'd1;
      4'd1:    code = 4'd2;
      4'd2:    code = 4'd3;
      4'd4:    code = 4'd4;
      4'd5:    code = 4'd5;
      4'd6:    code = 4'd6;
      4'd8:    code = 4'd7;
      4'd9:    code = 4'd8;
      4'd10:   code = 4'd9;
      4'd11:   code = KEY_C;
      4'd13:   code = 4'd0;
      4'd15:   code = KEY_D;
      default: code = KEY_OTHER;
    endcase
    return code;
  endfunction

endpackage

@@ rtl/core/keypad_range_temperature_alarm.sv @@
// Keypad range temperature alarm controller, single-pass datapath with a
// two-entry result buffer. Depends on krta_pkg.
`timescale 1ns / 1ps

// Takes one request per clock cycle: a key press, a temperature sample or a
// one-millisecond tick. Each request updates the controller state in the cycle
// it is accepted and produces exactly one result, held in a two-entry buffer
// and shown on the out_ ports from its head. Results queue in the buffer, so a
// request is still taken while one result waits to be taken; in_stall rises
// only when both entries are full. Configuration writes are taken in any cycle
// (cfg_ready is tied high) and should be made while no result is outstanding.
module keypad_range_temperature_alarm (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [3:0]  in_key_index,
  input  logic [6:0]  in_temperature,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_buzzer_on,
  output logic        out_out_of_range,
  output logic        out_entry_mode,
  output logic [2:0]  out_digits_taken,
  output logic [1:0]  out_entry_error,
  output logic        out_entry_done,
  output logic [6:0]  out_low_bound,
  output logic [6:0]  out_high_bound,
  output logic        out_snooze_pending,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [17:0] cfg_data
);

  typedef enum logic [1:0] {PH_IDLE, PH_ON, PH_OFF, PH_SNOOZE} phase_t;

  // Configuration
  logic [15:0] beep_half_r;
  logic [17:0] snooze_ticks_r;
  logic [6:0]  upper_lim_r;

  // Controller state
  logic [6:0]  lower_r, lower_nxt;
  logic [6:0]  upper_r, upper_nxt;
  logic [6:0]  temp_r, temp_nxt;
  logic        entering_r, entering_nxt;
  logic [1:0]  dcount_r, dcount_nxt;
  logic [6:0]  new_lower_r, new_lower_nxt;
  logic [6:0]  new_upper_r, new_upper_nxt;
  logic        snooze_req_r, snooze_req_nxt;
  phase_t      phase_r, phase_nxt;
  logic [17:0] pcount_r, pcount_nxt;

  // Result buffer
  logic        out_valid_r, skid_valid_r;
  krta_pkg::res_t out_r, skid_r, res;

  logic        push, pop;
  logic [3:0]  key;
  logic [2:0]  dcount_inc;
  logic        done;
  logic [1:0]  err;
  logic [6:0]  acc_base;
  logic [6:0]  acc_new;
  logic [17:0] beep_len, snooze_len;
  phase_t      phase_st;
  logic [17:0] pcount_st, pcount_dec;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid_r;
  assign push      = in_valid && !in_stall;
  assign pop       = out_valid_r && !out_stall;

  assign key        = krta_pkg::key_decode(in_key_index);
  assign beep_len   = (beep_half_r == 16'd0) ? 18'd1 : {2'b00, beep_half_r};
  assign snooze_len = (snooze_ticks_r == 18'd0) ? 18'd1 : snooze_ticks_r;

  always_comb begin
    lower_nxt      = lower_r;
    upper_nxt      = upper_r;
    temp_nxt       = temp_r;
    entering_nxt   = entering_r;
    dcount_nxt     = dcount_r;
    new_lower_nxt  = new_lower_r;
    new_upper_nxt  = new_upper_r;
    snooze_req_nxt = snooze_req_r;
    phase_nxt      = phase_r;
    pcount_nxt     = pcount_r;
    done           = 1'b0;
    err            = krta_pkg::ERR_NONE;
    dcount_inc     = {1'b0, dcount_r} + 3'd1;
    acc_base       = (dcount_r < 2'd2) ? new_lower_r : new_upper_r;
    // times ten plus digit, kept to seven bits
    acc_new        = (acc_base << 3) + (acc_base << 1) + {3'b000, key};
    phase_st       = phase_r;
    pcount_st      = pcount_r;
    pcount_dec     = 18'd0;

    case (in_op)
      krta_pkg::OP_KEY: begin
        if (!entering_r) begin
          if (key == krta_pkg::KEY_D) begin
            entering_nxt  = 1'b1;
            dcount_nxt    = 2'd0;
            new_lower_nxt = 7'd0;
            new_upper_nxt = 7'd0;
          end else if (key == krta_pkg::KEY_C) begin
            snooze_req_nxt = 1'b1;
          end
        end else if (key <= krta_pkg::KEY_DIGIT_MAX) begin
          if (dcount_r < 2'd2) new_lower_nxt = acc_new;
          else                 new_upper_nxt = acc_new;
          dcount_nxt = dcount_inc[1:0];
          if (dcount_inc == krta_pkg::ENTRY_DIGITS) begin
            done         = 1'b1;
            entering_nxt = 1'b0;
            dcount_nxt   = 2'd0;
            if (new_lower_nxt >= new_upper_nxt) begin
              err = krta_pkg::ERR_ORDER;
            end else if (new_upper_nxt >= upper_lim_r || new_lower_nxt == 7'd0) begin
              err = krta_pkg::ERR_LIMITS;
            end else begin
              lower_nxt      = new_lower_nxt;
              upper_nxt      = new_upper_nxt;
              snooze_req_nxt = 1'b0;
            end
          end
        end
      end
      krta_pkg::OP_TEMP: begin
        if (!entering_r) temp_nxt = in_temperature;
      end
      krta_pkg::OP_TICK: begin
        // start a phase on an out-of-range tick; that tick counts as its first
        if (phase_r == PH_IDLE && (temp_r < lower_r || temp_r > upper_r)) begin
          if (snooze_req_r) begin
            phase_st  = PH_SNOOZE;
            pcount_st = snooze_len;
          end else begin
            phase_st  = PH_ON;
            pcount_st = beep_len;
          end
        end
        pcount_dec = (pcount_st != 18'd0) ? pcount_st - 18'd1 : 18'd0;
        phase_nxt  = phase_st;
        pcount_nxt = pcount_st;
        if (phase_st != PH_IDLE) begin
          pcount_nxt = pcount_dec;
          if (pcount_dec == 18'd0) begin
            if (phase_st == PH_ON) begin
              phase_nxt  = PH_OFF;
              pcount_nxt = beep_len;
            end else begin
              if (phase_st == PH_SNOOZE) snooze_req_nxt = 1'b0;
              phase_nxt = PH_IDLE;
            end
          end
        end
      end
      default: ;
    endcase

    res.buzzer_on      = (phase_nxt == PH_ON);
    res.out_of_range   = (temp_nxt < lower_nxt) || (temp_nxt > upper_nxt);
    res.entry_mode     = entering_nxt;
    res.digits_taken   = done ? krta_pkg::ENTRY_DIGITS :
                         (entering_nxt ? {1'b0, dcount_nxt} : 3'd0);
    res.entry_error    = err;
    res.entry_done     = done;
    res.low_bound      = lower_nxt;
    res.high_bound     = upper_nxt;
    res.snooze_pending = snooze_req_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beep_half_r    <= krta_pkg::BEEP_HALF_RST;
      snooze_ticks_r <= krta_pkg::SNOOZE_RST;
      upper_lim_r    <= krta_pkg::UPPER_LIM_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        krta_pkg::CFG_BEEP_HALF: beep_half_r    <= cfg_data[15:0];
        krta_pkg::CFG_SNOOZE:    snooze_ticks_r <= cfg_data;
        krta_pkg::CFG_UPPER_LIM: upper_lim_r    <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lower_r      <= krta_pkg::LOWER_RST;
      upper_r      <= krta_pkg::UPPER_RST;
      temp_r       <= 7'd0;
      entering_r   <= 1'b0;
      dcount_r     <= 2'd0;
      new_lower_r  <= 7'd0;
      new_upper_r  <= 7'd0;
      snooze_req_r <= 1'b0;
      phase_r      <= PH_IDLE;
      pcount_r     <= 18'd0;
    end else if (push) begin
      lower_r      <= lower_nxt;
      upper_r      <= upper_nxt;
      temp_r       <= temp_nxt;
      entering_r   <= entering_nxt;
      dcount_r     <= dcount_nxt;
      new_lower_r  <= new_lower_nxt;
      new_upper_r  <= new_upper_nxt;
      snooze_req_r <= snooze_req_nxt;
      phase_r      <= phase_nxt;
      pcount_r     <= pcount_nxt;
    end
  end

  // Two-entry result buffer: out_r is the head, skid_r holds a second result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (pop) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= push;
      end
    end else if (push) begin
      if (out_valid_r) skid_valid_r <= 1'b1;
      else             out_valid_r  <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && skid_valid_r) begin
      out_r <= skid_r;
    end else if (push && (pop || !out_valid_r)) begin
      out_r <= res;
    end
    if (push && out_valid_r && !pop) begin
      skid_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_buzzer_on      = out_r.buzzer_on;
  assign out_out_of_range   = out_r.out_of_range;
  assign out_entry_mode     = out_r.entry_mode;
  assign out_digits_taken   = out_r.digits_taken;
  assign out_entry_error    = out_r.entry_error;
  assign out_entry_done     = out_r.entry_done;
  assign out_low_bound      = out_r.low_bound;
  assign out_high_bound     = out_r.high_bound;
  assign out_snooze_pending = out_r.snooze_pending;

  // A second buffered result needs a head in front of it
  a_skid_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("result buffer holds a second entry without a head");

  // A running phase always has ticks left
  a_phase_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != PH_IDLE |-> pcount_r != 18'd0)
    else $error("buzzer phase active with zero count");

  // A completed entry leaves entry mode with the digit count cleared
  a_entry_done: assert property (@(posedge clk) disable iff (!rst_n)
    (push && res.entry_done) |=> (!entering_r && dcount_r == 2'd0))
    else $error("entry completion left entry state behind");

endmodule

@@ bench/keypad_range_temperature_alarm_tb.sv @@
// Self-checking bench for the keypad range temperature alarm: directed entry
// sequences, then random traffic under several register settings and idling.
// Depends on krta_pkg and keypad_range_temperature_alarm.
`timescale 1ns / 1ps

module keypad_range_temperature_alarm_tb;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [3:0] KP_C = 4'd11;
  localparam logic [3:0] KP_D = 4'd15;
  localparam int QUIET_LIMIT = 3000;

  // Keypad index to key value, index 15 first
  localparam logic [15:0][3:0] KEYPAD_MAP = {
    krta_pkg::KEY_D, krta_pkg::KEY_OTHER, 4'd0, krta_pkg::KEY_OTHER,
    krta_pkg::KEY_C, 4'd9, 4'd8, 4'd7,
    krta_pkg::KEY_OTHER, 4'd6, 4'd5, 4'd4,
    krta_pkg::KEY_OTHER, 4'd3, 4'd2, 4'd1};
  // Digit to keypad index, digit 9 first
  localparam logic [9:0][3:0] DIGIT_KEY = {
    4'd10, 4'd9, 4'd8, 4'd6, 4'd5, 4'd4, 4'd2, 4'd1, 4'd0, 4'd13};
  // Keys that carry no digit
  localparam logic [5:0][3:0] IGNORED_KEYS = {
    4'd3, 4'd7, 4'd11, 4'd12, 4'd14, 4'd15};

  typedef enum logic [1:0] {BUZZ_IDLE, BUZZ_ON, BUZZ_OFF, BUZZ_SNOOZE} buzz_phase_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_op = krta_pkg::OP_KEY;
  logic [3:0]  in_key_index = 4'd0;
  logic [6:0]  in_temperature = 7'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_buzzer_on;
  logic        out_out_of_range;
  logic        out_entry_mode;
  logic [2:0]  out_digits_taken;
  logic [1:0]  out_entry_error;
  logic        out_entry_done;
  logic [6:0]  out_low_bound;
  logic [6:0]  out_high_bound;
  logic        out_snooze_pending;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = krta_pkg::CFG_BEEP_HALF;
  logic [17:0] cfg_data = 18'd0;

  keypad_range_temperature_alarm i_dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Alarm state as the block should hold it
  logic [15:0]  m_beep_half = krta_pkg::BEEP_HALF_RST;
  logic [17:0]  m_snooze_len = krta_pkg::SNOOZE_RST;
  logic [6:0]   m_upper_limit = krta_pkg::UPPER_LIM_RST;
  logic [6:0]   m_lower = krta_pkg::LOWER_RST;
  logic [6:0]   m_upper = krta_pkg::UPPER_RST;
  logic [6:0]   m_temp = 7'd0;
  logic         m_entering = 1'b0;
  logic [2:0]   m_digits = 3'd0;
  logic [6:0]   m_new_lower = 7'd0;
  logic [6:0]   m_new_upper = 7'd0;
  logic         m_snooze = 1'b0;
  buzz_phase_t  m_phase = BUZZ_IDLE;
  logic [17:0]  m_count = 18'd0;

  krta_pkg::res_t alarm_status_q [$];
  krta_pkg::res_t want;
  int          mismatches = 0;
  int unsigned items_sent = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          quiet_cycles = 0;

  function automatic logic temp_outside_bounds();
    return m_temp < m_lower || m_temp > m_upper;
  endfunction

  function automatic logic [17:0] beep_length();
    return (m_beep_half == 16'd0) ? 18'd1 : {2'b00, m_beep_half};
  endfunction

  task automatic predict_alarm_result(input logic [1:0] op, input logic [3:0] kidx,
                                      input logic [6:0] temp);
    logic [3:0] key;
    logic [1:0] err;
    logic       done;
    krta_pkg::res_t r;
    key = KEYPAD_MAP[kidx];
    err = krta_pkg::ERR_NONE;
    done = 1'b0;
    case (op)
      krta_pkg::OP_KEY: begin
        if (!m_entering) begin
          if (key == krta_pkg::KEY_D) begin
            m_entering = 1'b1;
            m_digits = 3'd0;
            m_new_lower = 7'd0;
            m_new_upper = 7'd0;
          end else if (key == krta_pkg::KEY_C) begin
            m_snooze = 1'b1;
          end
        end else if (key <= krta_pkg::KEY_DIGIT_MAX) begin
          if (m_digits < 3'd2) m_new_lower = 7'(m_new_lower * 10 + key);
          else m_new_upper = 7'(m_new_upper * 10 + key);
          m_digits = m_digits + 3'd1;
          if (m_digits >= krta_pkg::ENTRY_DIGITS) begin
            done = 1'b1;
            m_entering = 1'b0;
            if (m_new_lower >= m_new_upper) begin
              err = krta_pkg::ERR_ORDER;
            end else if (m_new_upper >= m_upper_limit || m_new_lower == 7'd0) begin
              err = krta_pkg::ERR_LIMITS;
            end else begin
              m_lower = m_new_lower;
              m_upper = m_new_upper;
              m_snooze = 1'b0;
            end
          end
        end
      end
      krta_pkg::OP_TEMP: begin
        if (!m_entering) m_temp = temp;
      end
      krta_pkg::OP_TICK: begin
        if (m_phase == BUZZ_IDLE && temp_outside_bounds()) begin
          if (m_snooze) begin
            m_phase = BUZZ_SNOOZE;
            m_count = (m_snooze_len == 18'd0) ? 18'd1 : m_snooze_len;
          end else begin
            m_phase = BUZZ_ON;
            m_count = beep_length();
          end
        end
        // The starting tick counts as the first of its phase
        if (m_phase != BUZZ_IDLE) begin
          if (m_count > 18'd0) m_count = m_count - 18'd1;
          if (m_count == 18'd0) begin
            if (m_phase == BUZZ_ON) begin
              m_phase = BUZZ_OFF;
              m_count = beep_length();
            end else begin
              if (m_phase == BUZZ_SNOOZE) m_snooze = 1'b0;
              m_phase = BUZZ_IDLE;
            end
          end
        end
      end
      default: ;
    endcase
    r.buzzer_on = (m_phase == BUZZ_ON);
    r.out_of_range = temp_outside_bounds();
    r.entry_mode = m_entering;
    r.digits_taken = done ? krta_pkg::ENTRY_DIGITS : (m_entering ? m_digits : 3'd0);
    if (done) m_digits = 3'd0;
    r.entry_error = err;
    r.entry_done = done;
    r.low_bound = m_lower;
    r.high_bound = m_upper;
    r.snooze_pending = m_snooze;
    alarm_status_q.push_back(r);
  endtask

  task automatic compare_field(input string fname, input int unsigned exp_val,
                               input int unsigned act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s expected %0d, actual %0d", $time, fname, exp_val, act_val);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (alarm_status_q.size() == 0) begin
        $display("%0t: result with no request outstanding", $time);
        mismatches++;
      end else begin
        want = alarm_status_q.pop_front();
        compare_field("buzzer_on", want.buzzer_on, out_buzzer_on);
        compare_field("out_of_range", want.out_of_range, out_out_of_range);
        compare_field("entry_mode", want.entry_mode, out_entry_mode);
        compare_field("digits_taken", want.digits_taken, out_digits_taken);
        compare_field("entry_error", want.entry_error, out_entry_error);
        compare_field("entry_done", want.entry_done, out_entry_done);
        compare_field("low_bound", want.low_bound, out_low_bound);
        compare_field("high_bound", want.high_bound, out_high_bound);
        compare_field("snooze_pending", want.snooze_pending, out_snooze_pending);
      end
    end
  end

  always @(negedge clk) out_stall <= ($urandom_range(99) < recv_idle_pct);

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
        || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("keypad_range_temperature_alarm: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Hold valid from one request to the next; drop it only during sender gaps (wait_all_results also drops it)
  task automatic send_request(input logic [1:0] op, input logic [3:0] kidx,
                              input logic [6:0] temp, input bit counts = 1'b1);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_key_index <= kidx;
    in_temperature <= temp;
    do @(posedge clk); while (in_stall);
    predict_alarm_result(op, kidx, temp);
    if (counts) items_sent++;
  endtask

  task automatic wait_all_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (alarm_status_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [17:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic apply_settings(input logic [15:0] beep, input logic [17:0] snooze,
                                input logic [6:0] limit);
    wait_all_results();
    write_register(krta_pkg::CFG_BEEP_HALF, {2'b00, beep});
    m_beep_half = beep;
    write_register(krta_pkg::CFG_SNOOZE, snooze);
    m_snooze_len = snooze;
    write_register(krta_pkg::CFG_UPPER_LIM, {11'd0, limit});
    m_upper_limit = limit;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // D then four digits; with noise, stray requests slip in and some entries stop short
  task automatic enter_range(input int lo, input int hi, input int noise_pct);
    int digits [4];
    digits[0] = lo / 10;
    digits[1] = lo % 10;
    digits[2] = hi / 10;
    digits[3] = hi % 10;
    send_request(krta_pkg::OP_KEY, KP_D, 7'($urandom_range(99)));
    for (int i = 0; i < 4; i++) begin
      if ($urandom_range(99) < noise_pct) begin
        case ($urandom_range(2))
          0: send_request(krta_pkg::OP_KEY, IGNORED_KEYS[$urandom_range(5)],
                          7'($urandom_range(99)), 1'b0);
          1: send_request(krta_pkg::OP_TEMP, 4'($urandom_range(15)),
                          7'($urandom_range(99)), 1'b0);
          default: send_request(krta_pkg::OP_TICK, 4'($urandom_range(15)),
                                7'($urandom_range(99)));
        endcase
      end
      if ($urandom_range(99) < noise_pct / 2) return;
      send_request(krta_pkg::OP_KEY, DIGIT_KEY[digits[i]], 7'($urandom_range(99)));
    end
  endtask

  task automatic run_random_traffic(input int unsigned n_items);
    int unsigned start;
    int sel;
    int lo;
    int hi;
    int t;
    start = items_sent;
    while (items_sent - start < n_items) begin
      sel = $urandom_range(99);
      if (sel < 25) begin
        if (m_upper_limit >= 7'd3 && $urandom_range(9) < 6) begin
          lo = $urandom_range(m_upper_limit - 2, 1);
          hi = $urandom_range(m_upper_limit - 1, lo + 1);
        end else begin
          lo = $urandom_range(99);
          hi = $urandom_range(99);
        end
        enter_range(lo, hi, 10);
      end else if (sel < 35) begin
        send_request(krta_pkg::OP_KEY, KP_C, 7'($urandom_range(99)));
      end else if (sel < 55) begin
        // Half the samples land on or beside a bound
        if ($urandom_range(1) == 0) begin
          t = $urandom_range(99);
        end else begin
          t = ($urandom_range(1) ? int'(m_lower) : int'(m_upper)) + $urandom_range(2) - 1;
          if (t < 0) t = 0;
          if (t > 99) t = 99;
        end
        send_request(krta_pkg::OP_TEMP, 4'($urandom_range(15)), 7'(t));
      end else if (sel < 92) begin
        repeat ($urandom_range(12, 1))
          send_request(krta_pkg::OP_TICK, 4'($urandom_range(15)), 7'($urandom_range(99)));
      end else begin
        send_request(2'($urandom_range(3)), 4'($urandom_range(15)),
                     7'($urandom_range(99)), 1'b0);
      end
    end
  endtask

  task automatic test_directed_entry();
    send_request(OP_UNUSED, 4'd0, 7'd0);
    send_request(krta_pkg::OP_TICK, 4'd15, 7'd99);
    send_request(krta_pkg::OP_TEMP, KP_D, 7'd99);
    send_request(krta_pkg::OP_TEMP, 4'd0, 7'd20);
    send_request(krta_pkg::OP_KEY, KP_C, 7'd0);
    send_request(krta_pkg::OP_KEY, 4'd3, 7'd0);
    send_request(krta_pkg::OP_KEY, KP_D, 7'd0);
    send_request(krta_pkg::OP_KEY, 4'd12, 7'd0);
    send_request(krta_pkg::OP_TEMP, 4'd0, 7'd50);
    send_request(krta_pkg::OP_TICK, 4'd0, 7'd0);
    send_request(krta_pkg::OP_KEY, DIGIT_KEY[2], 7'd0);
    send_request(krta_pkg::OP_KEY, DIGIT_KEY[0], 7'd0);
    send_request(krta_pkg::OP_KEY, KP_D, 7'd0);
    send_request(krta_pkg::OP_KEY, DIGIT_KEY[4], 7'd0);
    send_request(krta_pkg::OP_KEY, DIGIT_KEY[0], 7'd0);
    // lower not below upper, then a zero lower bound
    enter_range(30, 20, 0);
    enter_range(0, 45, 0);
  endtask

  task automatic test_short_durations();
    apply_settings(16'd1, 18'd1, 7'd99);
    run_random_traffic(230);
  endtask

  task automatic test_zero_registers();
    apply_settings(16'd0, 18'd0, 7'd0);
    run_random_traffic(230);
  endtask

  task automatic test_long_durations();
    apply_settings(16'hFFFF, 18'h3FFFF, 7'd1);
    run_random_traffic(230);
  endtask

  task automatic test_random_registers();
    apply_settings(16'($urandom_range(40, 1)), 18'($urandom_range(120, 1)),
                   7'($urandom_range(99, 2)));
    run_random_traffic(230);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 12;
    recv_idle_pct = 87;
    test_directed_entry();
    test_short_durations();
    test_zero_registers();
    send_idle_pct = 87;
    recv_idle_pct = 12;
    test_long_durations();
    test_random_registers();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_registers();
    wait_all_results();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("keypad_range_temperature_alarm: match");
    end else begin
      $display("keypad_range_temperature_alarm: mismatch");
    end
    $finish;
  end

endmodule
